// ===== rtl/i2c_eeprom_byte_master_unit_defines.svh =====
// Assertion macros for the I2C EEPROM byte master unit
`ifndef I2C_EEPROM_BYTE_MASTER_UNIT_DEFINES_SVH
`define I2C_EEPROM_BYTE_MASTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define I2CEM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define I2CEM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/i2cem_pkg.sv =====
// Types, codes and sequence tables shared by the I2C EEPROM byte master
package i2cem_pkg;

   localparam int ADDR_W      = 11;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_RECOVER = 2'd2;
   localparam logic [1:0] OP_ABORT   = 2'd3;

   localparam logic [1:0] STAT_OK           = 2'd0;
   localparam logic [1:0] STAT_ACK_TIMEOUT  = 2'd1;
   localparam logic [1:0] STAT_RECOVER_FAIL = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_UNIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_POLL_LIMIT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_CYCLE_UNITS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_CODE       = 2'd3;

   localparam logic [15:0] WAIT_1 = 16'd1;
   localparam logic [15:0] WAIT_2 = 16'd2;
   localparam logic [15:0] WAIT_4 = 16'd4;
   localparam logic [15:0] WAIT_5 = 16'd5;

   localparam logic [3:0] STEP_LAST = 4'd11;
   localparam logic [3:0] BYTE_BITS = 4'd8;
   localparam logic [3:0] RECOVER_CLOCKS = 4'd9;

   typedef enum logic [4:0] {
      PH_IDLE, PH_NEXT, PH_ST_B, PH_ST_C, PH_TX_BIT, PH_TX_HI, PH_TX_LO,
      PH_AK_B, PH_AK_S, PH_RX_HI, PH_RX_S, PH_NK_B, PH_NK_C, PH_SP_B,
      PH_RC_UP, PH_RC_S, PH_RC_H, PH_RC_L
   } phase_type;

   typedef enum logic [3:0] {
      EL_START, EL_SEND_CW, EL_SEND_AL, EL_SEND_CR, EL_SEND_D, EL_ACK,
      EL_READ, EL_NACK, EL_STOP, EL_WCYC, EL_RECOV, EL_END
   } elem_type;

   typedef struct packed {
      logic [7:0]  ticks_per_unit;
      logic [7:0]  ack_poll_limit;
      logic [15:0] write_cycle_units;
      logic [6:0]  device_code;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        op;
      logic [ADDR_W-1:0] address;
      logic [7:0]        write_data;
      logic              sda_in;
   } item_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic [1:0] status;
   } res_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  step_idx;
      logic [3:0]  bit_count;
      logic [7:0]  shift_byte;
      logic [15:0] unit_count;
      logic [7:0]  prescale;
      logic [8:0]  poll_count;
      logic [7:0]  held_data;
      logic [1:0]  held_op;
      logic        scl;
      logic        sda;
      logic        drive;
      logic [7:0]  last_read;
      logic [1:0]  last_status;
   } st_type;

   localparam st_type ST_RESET = '{
      phase: PH_IDLE, step_idx: 4'd0, bit_count: 4'd0, shift_byte: 8'd0,
      unit_count: 16'd0, prescale: 8'd0, poll_count: 9'd0, held_data: 8'd0,
      held_op: OP_READ, scl: 1'b1, sda: 1'b1, drive: 1'b1, last_read: 8'd0,
      last_status: STAT_OK
   };

   localparam cfg_type CFG_RESET = '{
      ticks_per_unit: 8'd1, ack_poll_limit: 8'd250, write_cycle_units: 16'd2000,
      device_code: 7'd80
   };

   localparam elem_type SEQ_READ [0:11] = '{
      EL_START, EL_SEND_CW, EL_ACK, EL_SEND_AL, EL_ACK, EL_START, EL_SEND_CR,
      EL_ACK, EL_READ, EL_NACK, EL_STOP, EL_END
   };
   localparam elem_type SEQ_WRITE [0:11] = '{
      EL_START, EL_SEND_CW, EL_ACK, EL_SEND_AL, EL_ACK, EL_SEND_D, EL_ACK,
      EL_STOP, EL_WCYC, EL_END, EL_END, EL_END
   };
   localparam elem_type SEQ_RECOVER [0:11] = '{
      EL_RECOV, EL_END, EL_END, EL_END, EL_END, EL_END, EL_END, EL_END,
      EL_END, EL_END, EL_END, EL_END
   };
   localparam elem_type SEQ_ABORT [0:11] = '{
      EL_STOP, EL_END, EL_END, EL_END, EL_END, EL_END, EL_END, EL_END,
      EL_END, EL_END, EL_END, EL_END
   };

   function automatic elem_type seq_elem(input logic [1:0] op, input logic [3:0] idx);
      logic [3:0] k;
      k = (idx > STEP_LAST) ? STEP_LAST : idx;
      case (op)
         OP_READ:    return SEQ_READ[k];
         OP_WRITE:   return SEQ_WRITE[k];
         OP_RECOVER: return SEQ_RECOVER[k];
         default:    return SEQ_ABORT[k];
      endcase
   endfunction

   function automatic logic [3:0] step_adv(input logic [3:0] idx);
      return (idx < STEP_LAST) ? idx + 4'd1 : idx;
   endfunction

   function automatic st_type set_wait(input st_type s, input logic [15:0] n,
                                       input phase_type ph);
      st_type r;
      r = s;
      r.phase = ph;
      r.unit_count = n;
      r.prescale = 8'd0;
      return r;
   endfunction

endpackage

// ===== rtl/i2c_eeprom_byte_master_unit.sv =====
// Top level of the I2C EEPROM byte master: item registers, state and handshakes
//
// Pin-level I2C master for a small serial EEPROM, driven by a stream of items.
// req channel: tuser is the kind (0 tick carrying the sampled SDA level,
// 1 start command with op, address and write data). Every item, tick or
// command, yields exactly one rsp item with the SCL/SDA pin levels, busy,
// a one-item done pulse, the last read byte and the status.
// The csr port writes ticks per unit, acknowledge poll limit, write-cycle
// units and device code; write it only while no operation is running.
// An accepted item is registered in the item register, processed, and shown on
// rsp from the rsp register. Throughput: one item per clock cycle while rsp
// is not stalled, set by the single state update between the item register
// and the rsp register. While rsp is stalled, one more item is taken into
// the item register; req_tready then drops until rsp_tready frees the output.
// Reset clears the pipeline, returns the state to idle with SCL and SDA
// high and driven, and loads the register defaults (1, 250, 2000, 0x50).
`include "i2c_eeprom_byte_master_unit_defines.svh"
module i2c_eeprom_byte_master_unit
   import i2cem_pkg::*;
#(
   parameter int ADDRESS_BITS = 11
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // op[1:0], address[12:2], write_data[20:13], sda_in[21], zero[23:22]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // kind[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
   // read_data[12:5], status[14:13], zero[15]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                 cfg;
   item_type                item_ff;
   item_type                item_in;
   logic                    item_valid_ff;
   logic                    item_valid_in;
   st_type                  st_ff;
   st_type                  st_in;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic [ADDRESS_BITS-1:0] addr_in;
   res_type                 res;
   logic                    rsp_tvalid_ff;
   logic                    rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;
   logic                    advance;
   logic                    accept;

   i2cem_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cem_step #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_step (
      .cur_st   (st_ff),
      .cur_addr (addr_ff),
      .item     (item_ff),
      .cfg      (cfg),
      .nxt_st   (st_in),
      .nxt_addr (addr_in),
      .res      (res)
   );

   assign advance    = item_valid_ff && (!rsp_tvalid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign item_in.kind       = req_tuser;
   assign item_in.op         = req_tdata[1:0];
   assign item_in.address    = req_tdata[12:2];
   assign item_in.write_data = req_tdata[20:13];
   assign item_in.sda_in     = req_tdata[21];

   assign item_valid_in = accept || (item_valid_ff && !advance);
   assign rsp_tvalid_in = advance || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         st_ff         <= ST_RESET;
         addr_ff       <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (advance) begin
            st_ff   <= st_in;
            addr_ff <= addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_tdata_ff <= {1'b0, res.status, res.read_data, res.done_res, res.busy_res,
                          res.sda_drive, res.sda_out, res.scl};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `I2CEM_ASSERT_IMP(a_wait_loaded, st_ff.phase != PH_IDLE, st_ff.unit_count != 16'd0, "busy without pending wait")
   `I2CEM_ASSERT_IMP(a_recover_status, st_ff.last_status == STAT_RECOVER_FAIL, st_ff.held_op == OP_RECOVER, "recovery status outside recovery")
   `I2CEM_ASSERT_NXT(a_item_to_rsp, advance, rsp_tvalid_ff, "processed item not presented")

endmodule

// ===== rtl/i2cem_csr.sv =====
// Configuration registers of the I2C EEPROM byte master
module i2cem_csr
   import i2cem_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TICKS_PER_UNIT:    cfg_in.ticks_per_unit = csr_wdata[7:0];
            CSR_ACK_POLL_LIMIT:    cfg_in.ack_poll_limit = csr_wdata[7:0];
            CSR_WRITE_CYCLE_UNITS: cfg_in.write_cycle_units = csr_wdata;
            CSR_DEVICE_CODE:       cfg_in.device_code = csr_wdata[6:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/i2cem_step.sv =====
// Next-state and result logic for one item of the I2C EEPROM byte master
module i2cem_step
   import i2cem_pkg::*;
#(
   parameter int ADDRESS_BITS = 11
)
(
   input  st_type                  cur_st,
   input  logic [ADDRESS_BITS-1:0] cur_addr,
   input  item_type                item,
   input  cfg_type                 cfg,
   output st_type                  nxt_st,
   output logic [ADDRESS_BITS-1:0] nxt_addr,
   output res_type                 res
);

   st_type                  n;
   logic [ADDRESS_BITS-1:0] a;
   logic                    done;
   logic                    go_next;
   logic                    expire;
   logic [1:0]              nx_op;
   logic [3:0]              nx_idx;
   logic [7:0]              tpu;
   logic [8:0]              pre;
   logic [15:0]             uc;
   logic [8:0]              pc;
   logic [7:0]              sh;
   logic [3:0]              bc;
   elem_type                elem;
   logic [ADDR_W-1:0]       addr_ext;
   logic [6:0]              ctl_dev;
   logic [7:0]              send_byte;

   always_comb begin
      n         = cur_st;
      a         = cur_addr;
      done      = 1'b0;
      go_next   = 1'b0;
      expire    = 1'b0;
      nx_op     = cur_st.held_op;
      nx_idx    = cur_st.step_idx;
      tpu       = (cfg.ticks_per_unit == 8'd0) ? 8'd1 : cfg.ticks_per_unit;
      pre       = {1'b0, cur_st.prescale} + 9'd1;
      uc        = (cur_st.unit_count != 16'd0) ? cur_st.unit_count - 16'd1
                                               : cur_st.unit_count;
      pc        = cur_st.poll_count + 9'd1;
      sh        = {cur_st.shift_byte[6:0], item.sda_in};
      bc        = cur_st.bit_count + 4'd1;
      elem      = EL_END;
      addr_ext  = '0;
      ctl_dev   = '0;
      send_byte = '0;

      if (item.kind) begin
         if (cur_st.phase == PH_IDLE && item.op != OP_ABORT) begin
            n.held_op     = item.op;
            a             = item.address[ADDRESS_BITS-1:0];
            n.held_data   = item.write_data;
            n.last_status = STAT_OK;
            go_next       = 1'b1;
            nx_op         = item.op;
            nx_idx        = 4'd0;
         end
      end else if (cur_st.phase != PH_IDLE) begin
         if (pre >= {1'b0, tpu}) begin
            n.prescale   = 8'd0;
            n.unit_count = uc;
            expire       = (uc == 16'd0);
         end else begin
            n.prescale = pre[7:0];
         end
      end

      if (expire) begin
         case (cur_st.phase)
            PH_NEXT: go_next = 1'b1;
            PH_ST_B: begin
               n.sda = 1'b0;
               n = set_wait(n, WAIT_4, PH_ST_C);
            end
            PH_ST_C: begin
               n.scl   = 1'b0;
               go_next = 1'b1;
            end
            PH_TX_BIT: begin
               if (cur_st.bit_count >= BYTE_BITS) begin
                  go_next = 1'b1;
               end else begin
                  n.sda = cur_st.shift_byte[7];
                  n = set_wait(n, WAIT_2, PH_TX_HI);
               end
            end
            PH_TX_HI: begin
               n.scl = 1'b1;
               n = set_wait(n, WAIT_2, PH_TX_LO);
            end
            PH_TX_LO: begin
               n.scl        = 1'b0;
               n.shift_byte = {cur_st.shift_byte[6:0], 1'b0};
               n.bit_count  = bc;
               n = set_wait(n, WAIT_2, PH_TX_BIT);
            end
            PH_AK_B: begin
               n.scl = 1'b1;
               n = set_wait(n, WAIT_1, PH_AK_S);
            end
            PH_AK_S: begin
               if (!item.sda_in) begin
                  n.scl   = 1'b0;
                  go_next = 1'b1;
               end else begin
                  n.poll_count = pc;
                  if (pc > {1'b0, cfg.ack_poll_limit}) begin
                     n.last_status = STAT_ACK_TIMEOUT;
                     n.held_op     = OP_ABORT;
                     n.step_idx    = 4'd0;
                     go_next       = 1'b1;
                     nx_op         = OP_ABORT;
                     nx_idx        = 4'd0;
                  end else begin
                     n = set_wait(n, WAIT_1, PH_AK_S);
                  end
               end
            end
            PH_RX_HI: begin
               n.scl = 1'b1;
               n = set_wait(n, WAIT_1, PH_RX_S);
            end
            PH_RX_S: begin
               n.shift_byte = sh;
               n.bit_count  = bc;
               if (bc >= BYTE_BITS) begin
                  n.last_read = sh;
                  go_next     = 1'b1;
               end else begin
                  n.scl = 1'b0;
                  n = set_wait(n, WAIT_2, PH_RX_HI);
               end
            end
            PH_NK_B: begin
               n.scl = 1'b1;
               n = set_wait(n, WAIT_2, PH_NK_C);
            end
            PH_NK_C: begin
               n.scl   = 1'b0;
               go_next = 1'b1;
            end
            PH_SP_B: begin
               n.scl = 1'b1;
               n.sda = 1'b1;
               n = set_wait(n, WAIT_4, PH_NEXT);
            end
            PH_RC_UP: begin
               n.scl = 1'b1;
               n = set_wait(n, WAIT_5, PH_RC_S);
            end
            PH_RC_S: begin
               if (!item.sda_in) begin
                  n.scl         = 1'b0;
                  n.last_status = STAT_RECOVER_FAIL;
                  n.phase       = PH_IDLE;
                  done          = 1'b1;
               end else begin
                  n.bit_count = bc;
                  if (bc >= RECOVER_CLOCKS) begin
                     n.drive = 1'b1;
                     n = set_wait(n, WAIT_5, PH_RC_H);
                  end else begin
                     n.scl = 1'b0;
                     n = set_wait(n, WAIT_5, PH_RC_UP);
                  end
               end
            end
            PH_RC_H: begin
               n.sda = 1'b1;
               n = set_wait(n, WAIT_5, PH_RC_L);
            end
            PH_RC_L: begin
               n.sda   = 1'b0;
               go_next = 1'b1;
            end
            default: n.phase = PH_IDLE;
         endcase
      end

      if (go_next) begin
         elem       = seq_elem(nx_op, nx_idx);
         n.step_idx = step_adv(nx_idx);
         addr_ext   = ADDR_W'(a);
         ctl_dev    = cfg.device_code | {4'b0000, addr_ext[10:8]};
         case (elem)
            EL_SEND_CW: send_byte = {ctl_dev, 1'b0};
            EL_SEND_CR: send_byte = {ctl_dev, 1'b1};
            EL_SEND_AL: send_byte = addr_ext[7:0];
            default:    send_byte = n.held_data;
         endcase
         case (elem)
            EL_START: begin
               n.drive = 1'b1;
               n.sda   = 1'b1;
               n.scl   = 1'b1;
               n = set_wait(n, WAIT_4, PH_ST_B);
            end
            EL_SEND_CW, EL_SEND_CR, EL_SEND_AL, EL_SEND_D: begin
               n.drive      = 1'b1;
               n.scl        = 1'b0;
               n.shift_byte = send_byte;
               n.bit_count  = 4'd0;
               n.sda        = send_byte[7];
               n = set_wait(n, WAIT_2, PH_TX_HI);
            end
            EL_ACK: begin
               n.drive      = 1'b0;
               n.sda        = 1'b1;
               n.poll_count = 9'd0;
               n = set_wait(n, WAIT_1, PH_AK_B);
            end
            EL_READ: begin
               n.drive      = 1'b0;
               n.bit_count  = 4'd0;
               n.shift_byte = 8'd0;
               n.scl        = 1'b0;
               n = set_wait(n, WAIT_2, PH_RX_HI);
            end
            EL_NACK: begin
               n.scl   = 1'b0;
               n.drive = 1'b1;
               n.sda   = 1'b1;
               n = set_wait(n, WAIT_2, PH_NK_B);
            end
            EL_STOP: begin
               n.drive = 1'b1;
               n.scl   = 1'b0;
               n.sda   = 1'b0;
               n = set_wait(n, WAIT_4, PH_SP_B);
            end
            EL_WCYC: begin
               if (cfg.write_cycle_units != 16'd0) begin
                  n = set_wait(n, cfg.write_cycle_units, PH_NEXT);
               end else begin
                  n.step_idx = step_adv(step_adv(nx_idx));
                  n.phase    = PH_IDLE;
                  done       = 1'b1;
               end
            end
            EL_RECOV: begin
               n.drive     = 1'b0;
               n.bit_count = 4'd0;
               n.scl       = 1'b0;
               n = set_wait(n, WAIT_5, PH_RC_UP);
            end
            default: begin
               n.phase = PH_IDLE;
               done    = 1'b1;
            end
         endcase
      end
   end

   assign nxt_st   = n;
   assign nxt_addr = a;

   assign res.scl       = n.scl;
   assign res.sda_out   = n.sda;
   assign res.sda_drive = n.drive;
   assign res.busy_res  = (n.phase != PH_IDLE);
   assign res.done_res  = done;
   assign res.read_data = n.last_read;
   assign res.status    = n.last_status;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the I2C EEPROM byte master, predicted and checked per item
module tb_top;
   import i2cem_pkg::*;

   localparam int   CYCLE_LIMIT  = 3000000;
   localparam int   PRINT_LIMIT  = 50;
   localparam int   ITEM_BUDGET  = 1800;
   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_COMMAND = 1'b1;

   typedef enum logic [4:0] {
      MS_IDLE, MS_NEXT, MS_ST_B, MS_ST_C, MS_TX_BIT, MS_TX_HI, MS_TX_LO,
      MS_AK_B, MS_AK_S, MS_RX_BIT, MS_RX_HI, MS_RX_S, MS_NK_B, MS_NK_C,
      MS_SP_B, MS_RC_CLK, MS_RC_UP, MS_RC_S, MS_RC_H, MS_RC_L
   } master_phase_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // op[1:0], address[12:2], write_data[20:13], sda_in[21], zero[23:22]
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   // kind[0]
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
   // read_data[12:5], status[14:13], zero[15]
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   i2c_eeprom_byte_master_unit DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_index, .csr_wdata
   );

   // register copy
   logic [7:0]    unit_ticks, poll_limit;
   logic [15:0]   cycle_units;
   logic [6:0]    dev_code;

   // master state copy
   master_phase_type ph;
   logic [3:0]    seq_idx, bit_cnt;
   logic [7:0]    shreg, presc, held_byte, read_q;
   logic [15:0]   unit_cnt;
   logic [8:0]    poll_cnt;
   logic [10:0]   held_adr;
   logic [1:0]    held_op, status_q;
   logic          scl_q, sda_q, drv_q, done_q;

   res_type expected_pins[$];
   int      errors       = 0;
   int      cycles       = 0;
   int      sent_items   = 0;
   bit      idle_on      = 1'b1;
   int      hold_request = 0;
   int      hold_left    = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void reset_predictor;
      unit_ticks = 8'd1; poll_limit = 8'd250; cycle_units = 16'd2000; dev_code = 7'd80;
      ph = MS_IDLE; seq_idx = '0; bit_cnt = '0; shreg = '0; presc = '0;
      unit_cnt = '0; poll_cnt = '0; held_adr = '0; held_byte = '0; held_op = OP_READ;
      read_q = '0; status_q = STAT_OK;
      scl_q = 1'b1; sda_q = 1'b1; drv_q = 1'b1; done_q = 1'b0;
   endfunction

   function automatic elem_type op_element(input logic [1:0] op, input logic [3:0] idx);
      case (op)
         OP_READ:
            case (idx)
               0: return EL_START;
               1: return EL_SEND_CW;
               2: return EL_ACK;
               3: return EL_SEND_AL;
               4: return EL_ACK;
               5: return EL_START;
               6: return EL_SEND_CR;
               7: return EL_ACK;
               8: return EL_READ;
               9: return EL_NACK;
               10: return EL_STOP;
               default: return EL_END;
            endcase
         OP_WRITE:
            case (idx)
               0: return EL_START;
               1: return EL_SEND_CW;
               2: return EL_ACK;
               3: return EL_SEND_AL;
               4: return EL_ACK;
               5: return EL_SEND_D;
               6: return EL_ACK;
               7: return EL_STOP;
               8: return EL_WCYC;
               default: return EL_END;
            endcase
         OP_RECOVER: return (idx == 0) ? EL_RECOV : EL_END;
         default: return (idx == 0) ? EL_STOP : EL_END;
      endcase
   endfunction

   function automatic logic [7:0] control_byte(input logic rw);
      logic [6:0] code;
      code = dev_code | {4'b0000, held_adr[10:8]};
      return {code, rw};
   endfunction

   function automatic bit arm_wait(input logic [15:0] n, input master_phase_type nxt);
      ph = nxt;
      if (n == 16'd0) return 1'b0;
      unit_cnt = n;
      presc = 8'd0;
      return 1'b1;
   endfunction

   function automatic void start_send(input logic [7:0] b);
      drv_q = 1'b1;
      scl_q = 1'b0;
      shreg = b;
      bit_cnt = 4'd0;
      ph = MS_TX_BIT;
   endfunction

   // walk the pin sequence until the next wait or the end of the operation
   function automatic void run_sequencer(input logic sda);
      elem_type e;
      while (1'b1) begin
         case (ph)
            MS_NEXT: begin
               e = op_element(held_op, seq_idx);
               if (seq_idx < STEP_LAST) seq_idx = seq_idx + 4'd1;
               case (e)
                  EL_START: begin
                     drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
                     if (arm_wait(16'd4, MS_ST_B)) return;
                  end
                  EL_SEND_CW: start_send(control_byte(1'b0));
                  EL_SEND_CR: start_send(control_byte(1'b1));
                  EL_SEND_AL: start_send(held_adr[7:0]);
                  EL_SEND_D: start_send(held_byte);
                  EL_ACK: begin
                     drv_q = 1'b0; sda_q = 1'b1; poll_cnt = 9'd0;
                     if (arm_wait(16'd1, MS_AK_B)) return;
                  end
                  EL_READ: begin
                     drv_q = 1'b0; bit_cnt = 4'd0; shreg = 8'd0;
                     ph = MS_RX_BIT;
                  end
                  EL_NACK: begin
                     scl_q = 1'b0; drv_q = 1'b1; sda_q = 1'b1;
                     if (arm_wait(16'd2, MS_NK_B)) return;
                  end
                  EL_STOP: begin
                     drv_q = 1'b1; scl_q = 1'b0; sda_q = 1'b0;
                     if (arm_wait(16'd4, MS_SP_B)) return;
                  end
                  EL_WCYC: begin
                     if (arm_wait(cycle_units, MS_NEXT)) return;
                  end
                  EL_RECOV: begin
                     drv_q = 1'b0; bit_cnt = 4'd0;
                     ph = MS_RC_CLK;
                  end
                  default: begin
                     ph = MS_IDLE;
                     done_q = 1'b1;
                     return;
                  end
               endcase
            end
            MS_ST_B: begin
               sda_q = 1'b0;
               if (arm_wait(16'd4, MS_ST_C)) return;
            end
            MS_ST_C: begin
               scl_q = 1'b0;
               ph = MS_NEXT;
            end
            MS_TX_BIT: begin
               if (bit_cnt >= 4'd8) ph = MS_NEXT;
               else begin
                  sda_q = shreg[7];
                  if (arm_wait(16'd2, MS_TX_HI)) return;
               end
            end
            MS_TX_HI: begin
               scl_q = 1'b1;
               if (arm_wait(16'd2, MS_TX_LO)) return;
            end
            MS_TX_LO: begin
               scl_q = 1'b0;
               shreg = {shreg[6:0], 1'b0};
               bit_cnt = bit_cnt + 4'd1;
               if (arm_wait(16'd2, MS_TX_BIT)) return;
            end
            MS_AK_B: begin
               scl_q = 1'b1;
               if (arm_wait(16'd1, MS_AK_S)) return;
            end
            MS_AK_S: begin
               if (!sda) begin
                  scl_q = 1'b0;
                  ph = MS_NEXT;
               end else begin
                  poll_cnt = poll_cnt + 9'd1;
                  if (poll_cnt > {1'b0, poll_limit}) begin
                     status_q = STAT_ACK_TIMEOUT;
                     held_op = OP_ABORT;
                     seq_idx = 4'd0;
                     ph = MS_NEXT;
                  end else if (arm_wait(16'd1, MS_AK_S)) return;
               end
            end
            MS_RX_BIT: begin
               if (bit_cnt >= 4'd8) begin
                  read_q = shreg;
                  ph = MS_NEXT;
               end else begin
                  scl_q = 1'b0;
                  if (arm_wait(16'd2, MS_RX_HI)) return;
               end
            end
            MS_RX_HI: begin
               scl_q = 1'b1;
               if (arm_wait(16'd1, MS_RX_S)) return;
            end
            MS_RX_S: begin
               shreg = {shreg[6:0], sda};
               bit_cnt = bit_cnt + 4'd1;
               ph = MS_RX_BIT;
            end
            MS_NK_B: begin
               scl_q = 1'b1;
               if (arm_wait(16'd2, MS_NK_C)) return;
            end
            MS_NK_C: begin
               scl_q = 1'b0;
               ph = MS_NEXT;
            end
            MS_SP_B: begin
               scl_q = 1'b1; sda_q = 1'b1;
               if (arm_wait(16'd4, MS_NEXT)) return;
            end
            MS_RC_CLK: begin
               if (bit_cnt >= 4'd9) begin
                  drv_q = 1'b1;
                  if (arm_wait(16'd5, MS_RC_H)) return;
               end else begin
                  scl_q = 1'b0;
                  if (arm_wait(16'd5, MS_RC_UP)) return;
               end
            end
            MS_RC_UP: begin
               scl_q = 1'b1;
               if (arm_wait(16'd5, MS_RC_S)) return;
            end
            MS_RC_S: begin
               if (!sda) begin
                  scl_q = 1'b0;
                  status_q = STAT_RECOVER_FAIL;
                  ph = MS_IDLE;
                  done_q = 1'b1;
                  return;
               end
               bit_cnt = bit_cnt + 4'd1;
               ph = MS_RC_CLK;
            end
            MS_RC_H: begin
               sda_q = 1'b1;
               if (arm_wait(16'd5, MS_RC_L)) return;
            end
            MS_RC_L: begin
               sda_q = 1'b0;
               ph = MS_NEXT;
            end
            default: begin
               ph = MS_IDLE;
               return;
            end
         endcase
      end
   endfunction

   function automatic void advance_master(input item_type it);
      res_type pins;
      done_q = 1'b0;
      if (it.kind == KIND_COMMAND) begin
         if (ph == MS_IDLE && it.op != OP_ABORT) begin
            held_op = it.op;
            held_adr = it.address;
            held_byte = it.write_data;
            status_q = STAT_OK;
            seq_idx = 4'd0;
            ph = MS_NEXT;
            run_sequencer(1'b0);
         end
      end else if (ph != MS_IDLE) begin
         presc = presc + 8'd1;
         if (presc >= ((unit_ticks == 8'd0) ? 8'd1 : unit_ticks)) begin
            presc = 8'd0;
            if (unit_cnt > 16'd0) unit_cnt = unit_cnt - 16'd1;
            if (unit_cnt == 16'd0) run_sequencer(it.sda_in);
         end
      end
      pins.scl = scl_q;
      pins.sda_out = sda_q;
      pins.sda_drive = drv_q;
      pins.busy_res = (ph != MS_IDLE);
      pins.done_res = done_q;
      pins.read_data = read_q;
      pins.status = status_q;
      expected_pins.push_back(pins);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("%0t ns: %s got %0h, want %0h", $time, what, got, want);
   endtask

   task automatic compare_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : rsp_check
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pins.size() == 0) begin
            report_mismatch("unexpected item", int'(rsp_tdata), 0);
         end else begin
            want = expected_pins.pop_front();
            compare_field("scl", int'(rsp_tdata[0]), int'(want.scl));
            compare_field("sda_out", int'(rsp_tdata[1]), int'(want.sda_out));
            compare_field("sda_drive", int'(rsp_tdata[2]), int'(want.sda_drive));
            compare_field("busy_res", int'(rsp_tdata[3]), int'(want.busy_res));
            compare_field("done_res", int'(rsp_tdata[4]), int'(want.done_res));
            compare_field("read_data", int'(rsp_tdata[12:5]), int'(want.read_data));
            compare_field("status", int'(rsp_tdata[14:13]), int'(want.status));
         end
      end
   end

   // receiver: short random stalls, or one long hold when requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left = hold_request - 1;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic item_type tick_item(input logic sda);
      item_type it;
      it.kind = KIND_TICK;
      it.op = 2'($urandom_range(0, 3));
      it.address = 11'($urandom_range(0, 2047));
      it.write_data = 8'($urandom_range(0, 255));
      it.sda_in = sda;
      return it;
   endfunction

   function automatic item_type command_item(input logic [1:0] op, input logic [10:0] adr,
                                             input logic [7:0] dat);
      item_type it;
      it.kind = KIND_COMMAND;
      it.op = op;
      it.address = adr;
      it.write_data = dat;
      it.sda_in = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // slave side of the bus: ack, recovery line level, random data elsewhere
   function automatic logic bus_level(input int nack_pct, input int stuck_pct);
      case (ph)
         MS_AK_S: return ($urandom_range(1, 100) <= nack_pct);
         MS_RC_S: return !($urandom_range(1, 100) <= stuck_pct);
         default: return ($urandom_range(0, 1) != 0);
      endcase
   endfunction

   task automatic send_item(input item_type it);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {2'b00, it.sda_in, it.write_data, it.address, it.op};
      do @(posedge clock); while (!req_tready);
      sent_items++;
      advance_master(it);
   endtask

   task automatic run_operation(input logic [1:0] op, input logic [10:0] adr,
                                input logic [7:0] dat, input int nack_pct,
                                input int stuck_pct, input bit noisy);
      item_type it;
      send_item(command_item(op, adr, dat));
      while (ph != MS_IDLE) begin
         if (noisy && $urandom_range(0, 31) == 0)
            it = command_item(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
                              8'($urandom_range(0, 255)));
         else
            it = tick_item(bus_level(nack_pct, stuck_pct));
         send_item(it);
      end
   endtask

   task automatic idle_drain;
      req_tvalid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_TICKS_PER_UNIT:    unit_ticks = val[7:0];
         CSR_ACK_POLL_LIMIT:    poll_limit = val[7:0];
         CSR_WRITE_CYCLE_UNITS: cycle_units = val;
         CSR_DEVICE_CODE:       dev_code = val[6:0];
         default:               ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] tpu, input logic [7:0] apl,
                            input logic [15:0] wcu, input logic [6:0] dev);
      idle_drain();
      write_reg(CSR_TICKS_PER_UNIT, CSR_DATA_W'(tpu));
      write_reg(CSR_ACK_POLL_LIMIT, CSR_DATA_W'(apl));
      write_reg(CSR_WRITE_CYCLE_UNITS, wcu);
      write_reg(CSR_DEVICE_CODE, CSR_DATA_W'(dev));
   endtask

   task automatic test_idle_and_defaults;
      repeat (3) send_item(tick_item(1'($urandom_range(0, 1))));
      send_item(command_item(OP_ABORT, 11'h7FF, 8'hFF));
      run_operation(OP_READ, 11'h7FF, 8'h00, 0, 0, 1'b0);
      run_operation(OP_RECOVER, 11'h000, 8'h00, 0, 0, 1'b1);
   endtask

   task automatic test_field_extremes;
      configure(8'd0, 8'd250, 16'd0, 7'd0);
      run_operation(OP_WRITE, 11'h7FF, 8'hFF, 0, 0, 1'b0);
      configure(8'd1, 8'd3, 16'd1, 7'd127);
      run_operation(OP_READ, 11'h555, 8'h00, 0, 0, 1'b0);
   endtask

   task automatic test_ack_timeout;
      configure(8'd1, 8'd0, 16'd0, 7'd80);
      run_operation(OP_READ, 11'h123, 8'h00, 100, 0, 1'b0);
      configure(8'd1, 8'd255, 16'd0, 7'd80);
      run_operation(OP_WRITE, 11'h0F0, 8'hC3, 100, 0, 1'b0);
      configure(8'd1, 8'd2, 16'd0, 7'd80);
      run_operation(OP_READ, 11'($urandom_range(0, 2047)), 8'h00, 50, 0, 1'b0);
   endtask

   task automatic test_bus_recovery;
      configure(8'd1, 8'd4, 16'd0, 7'd80);
      run_operation(OP_RECOVER, 11'h000, 8'h00, 0, 100, 1'b0);
      run_operation(OP_RECOVER, 11'h000, 8'h00, 0, 8, 1'b0);
      configure(8'd8, 8'd4, 16'd0, 7'd80);
      run_operation(OP_RECOVER, 11'h000, 8'h00, 0, 100, 1'b0);
   endtask

   task automatic test_write_cycle_extremes;
      configure(8'd1, 8'd4, 16'd128, 7'd80);
      run_operation(OP_WRITE, 11'h3FF, 8'h81, 0, 0, 1'b0);
   endtask

   task automatic test_output_backpressure;
      configure(8'd1, 8'd4, 16'd2, 7'd80);
      hold_request = 300;
      run_operation(OP_READ, 11'h321, 8'h00, 0, 0, 1'b0);
   endtask

   task automatic test_random_traffic;
      int nack_pct;
      int stuck_pct;
      do begin
         configure(8'($urandom_range(0, 2)), 8'($urandom_range(0, 3)),
                   16'($urandom_range(0, 6)), 7'($urandom_range(0, 127)));
         repeat (2) begin
            case ($urandom_range(0, 5))
               0: nack_pct = 100;
               1: nack_pct = 40;
               default: nack_pct = 0;
            endcase
            case ($urandom_range(0, 7))
               0: stuck_pct = 100;
               1: stuck_pct = 5;
               default: stuck_pct = 0;
            endcase
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 4)) send_item(tick_item(1'($urandom_range(0, 1))));
            run_operation(2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)),
                          8'($urandom_range(0, 255)), nack_pct, stuck_pct, 1'b1);
         end
      end while (sent_items < ITEM_BUDGET);
   endtask

   task automatic test_steady_stream;
      idle_on = 1'b0;
      configure(8'd1, 8'd3, 16'd2, 7'd80);
      run_operation(OP_READ, 11'($urandom_range(0, 2047)), 8'h00, 0, 0, 1'b0);
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_idle_and_defaults();
      test_field_extremes();
      test_ack_timeout();
      test_bus_recovery();
      test_write_cycle_extremes();
      test_output_backpressure();
      test_random_traffic();
      test_steady_stream();
      idle_drain();
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
